FILE: rtl/blsq_pkg.sv
package blsq_pkg;

	localparam logic [2:0] CMD_PUSH   = 3'd0;
	localparam logic [2:0] CMD_POP    = 3'd1;
	localparam logic [2:0] CMD_PEEK   = 3'd2;
	localparam logic [2:0] CMD_STATUS = 3'd3;
	localparam logic [2:0] CMD_MAX    = 3'd4;
	localparam logic [2:0] CMD_EVENS  = 3'd5;
	localparam logic [2:0] CMD_ODDS   = 3'd6;

	localparam logic [1:0] OC_OK    = 2'd0;
	localparam logic [1:0] OC_EMPTY = 2'd1;
	localparam logic [1:0] OC_FULL  = 2'd2;
	localparam logic [1:0] OC_NONE  = 2'd3;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_POP,
		OP_PEEK,
		OP_STATUS,
		OP_MAX,
		OP_EVENS,
		OP_ODDS,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] push_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         outcome;
		logic signed [31:0] word;
		logic [3:0]         occupancy;
		logic [3:0]         free_slots;
		logic               last;
	} out_item_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] data;
	} op_item_t;

endpackage

FILE: rtl/bounded_lifo_stack_with_queries_core.sv
// Bounded LIFO stack of DEPTH signed 32-bit words with push, pop, peek, status, max and
// even/odd listing commands. Items enter through a two-entry command queue and are carried
// out one at a time by an executor holding the stack in a memory with one write port and
// one registered read port. A push, or any command that finds the stack empty (or status
// on a full stack), is answered straight from the idle state; pop and peek read the top word;
// status, max, evens and odds read each stored element in turn through that single read
// port. The unused command code is dropped at the queue and gives no result. Results wait in
// an output register; while one is held up the queue accepts items until both entries are full.
module bounded_lifo_stack_with_queries_core
	import blsq_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp
);

	logic     q_valid;
	logic     q_ready;
	op_item_t q_item;

	blsq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item)
	);

	blsq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/blsq_front.sv
module blsq_front
	import blsq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  in_item_t req,
	output logic     q_valid,
	input  logic     q_ready,
	output op_item_t q_item
);

	op_item_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	op_item_t   cls;
	logic       accept;
	logic       push_q;
	logic       pop_q;

	// classify the command; the unused code is dropped here
	always_comb begin
		cls.data = req.push_data;
		case (req.command)
			CMD_PUSH:   cls.op = OP_PUSH;
			CMD_POP:    cls.op = OP_POP;
			CMD_PEEK:   cls.op = OP_PEEK;
			CMD_STATUS: cls.op = OP_STATUS;
			CMD_MAX:    cls.op = OP_MAX;
			CMD_EVENS:  cls.op = OP_EVENS;
			CMD_ODDS:   cls.op = OP_ODDS;
			default:    cls.op = OP_NOP;
		endcase
	end

	assign req_ready = (fill_q != 2'd2);
	assign accept    = req_valid && req_ready;
	assign push_q    = accept && (cls.op != OP_NOP);
	assign q_valid   = (fill_q != 2'd0);
	assign pop_q     = q_valid && q_ready;
	assign q_item    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push_q)
				wr_ptr_q <= !wr_ptr_q;
			if (pop_q)
				rd_ptr_q <= !rd_ptr_q;
			case ({push_q, pop_q})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_q)
			entry_q[wr_ptr_q] <= cls;
	end

endmodule

FILE: rtl/blsq_back.sv
module blsq_back
	import blsq_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_ready,
	input  op_item_t  q_item,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_q;
	logic signed [31:0] hold_q;
	logic signed [31:0] best_q;
	out_item_t          out_q;
	logic               out_valid_q;

	state_t          st_q, st_d;
	op_t             op_q, op_d;
	logic [AW-1:0]   idx_q, idx_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic            hold_valid_q, hold_valid_d;
	logic            can_emit;
	logic            emit;
	logic [1:0]      emit_oc;
	logic signed [31:0] emit_word;
	logic            emit_last;
	out_item_t       emit_item;
	logic            we;
	logic            load_hold;
	logic            load_best;
	logic            last_idx;
	logic            match;

	assign can_emit = !out_valid_q || rsp_ready;
	assign last_idx = (idx_q == AW'(cnt_q - CW'(1)));

	always_comb begin
		case (op_q)
			OP_STATUS: match = 1'b1;
			OP_EVENS:  match = !rd_q[0];
			OP_ODDS:   match = rd_q[0];
			default:   match = 1'b0;
		endcase
	end

	always_comb begin
		st_d         = st_q;
		op_d         = op_q;
		idx_d        = idx_q;
		cnt_d        = cnt_q;
		hold_valid_d = hold_valid_q;
		q_ready      = 1'b0;
		emit         = 1'b0;
		emit_oc      = OC_OK;
		emit_word    = '0;
		emit_last    = 1'b1;
		we           = 1'b0;
		load_hold    = 1'b0;
		load_best    = 1'b0;
		case (st_q)
			ST_IDLE: begin
				q_ready = can_emit;
				if (q_valid && can_emit) begin
					op_d         = q_item.op;
					hold_valid_d = 1'b0;
					if (q_item.op == OP_PUSH) begin
						emit = 1'b1;
						if (cnt_q >= DEPTH_C) begin
							emit_oc = OC_FULL;
						end else begin
							we        = 1'b1;
							cnt_d     = cnt_q + CW'(1);
							emit_word = q_item.data;
						end
					end else if (q_item.op == OP_NOP) begin
						st_d = ST_IDLE;
					end else if (cnt_q == '0) begin
						emit    = 1'b1;
						emit_oc = OC_EMPTY;
					end else if (q_item.op == OP_STATUS && cnt_q == DEPTH_C) begin
						emit    = 1'b1;
						emit_oc = OC_FULL;
					end else if (q_item.op == OP_POP || q_item.op == OP_PEEK) begin
						idx_d = AW'(cnt_q - CW'(1));
						st_d  = ST_READ;
					end else begin
						idx_d = '0;
						st_d  = ST_READ;
					end
				end
			end
			ST_READ: begin
				st_d = ST_EVAL;
			end
			ST_EVAL: begin
				case (op_q)
					OP_POP, OP_PEEK: begin
						if (can_emit) begin
							emit      = 1'b1;
							emit_word = rd_q;
							if (op_q == OP_POP)
								cnt_d = cnt_q - CW'(1);
							st_d = ST_IDLE;
						end
					end
					OP_MAX: begin
						load_best = (idx_q == '0) || (rd_q > best_q);
						if (last_idx) begin
							st_d = ST_FINISH;
						end else begin
							idx_d = idx_q + AW'(1);
							st_d  = ST_READ;
						end
					end
					default: begin
						// a match is held back until the next one shows it is not the last
						if (!(match && hold_valid_q) || can_emit) begin
							if (match) begin
								emit         = hold_valid_q;
								emit_word    = hold_q;
								emit_last    = 1'b0;
								load_hold    = 1'b1;
								hold_valid_d = 1'b1;
							end
							if (last_idx) begin
								st_d = ST_FINISH;
							end else begin
								idx_d = idx_q + AW'(1);
								st_d  = ST_READ;
							end
						end
					end
				endcase
			end
			ST_FINISH: begin
				if (can_emit) begin
					emit = 1'b1;
					st_d = ST_IDLE;
					if (op_q == OP_MAX) begin
						emit_word = best_q;
					end else if (hold_valid_q) begin
						emit_word = hold_q;
					end else begin
						emit_oc = OC_NONE;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit_item.outcome    = emit_oc;
		emit_item.word       = emit_word;
		emit_item.occupancy  = 4'(cnt_d);
		emit_item.free_slots = 4'(DEPTH_C - cnt_d);
		emit_item.last       = emit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			op_q         <= OP_NOP;
			idx_q        <= '0;
			cnt_q        <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			st_q         <= st_d;
			op_q         <= op_d;
			idx_q        <= idx_d;
			cnt_q        <= cnt_d;
			hold_valid_q <= hold_valid_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[cnt_q[AW-1:0]] <= q_item.data;
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= emit_item;
		if (load_hold)
			hold_q <= rd_q;
		if (load_best)
			best_q <= rd_q;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("element count beyond depth");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.outcome == OC_EMPTY |-> out_q.occupancy == 4'd0)
		else $error("empty result with nonzero occupancy");

	a_eval_order: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EVAL |-> $past(st_q) == ST_READ || $past(st_q) == ST_EVAL)
		else $error("evaluation without a memory read");

	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !emit_last |-> st_q == ST_EVAL && hold_valid_q)
		else $error("non-final result outside a listing");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp_ready |=> $stable(out_q))
		else $error("pending result overwritten");

endmodule

FILE: test/bounded_lifo_stack_with_queries_core_tb.sv
module bounded_lifo_stack_with_queries_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import blsq_pkg::*;

	localparam int DEPTH = 8;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	in_item_t  req;
	logic      rsp_valid;
	logic      rsp_ready;
	out_item_t rsp;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int commands_sent = 0;
	int commands_ignored = 0;
	int results_checked = 0;
	int full_reports = 0;
	int empty_reports = 0;
	int none_reports = 0;

	logic signed [31:0] stack_words [DEPTH];
	int unsigned        words_held = 0;
	out_item_t          pending_rsp [$];

	bounded_lifo_stack_with_queries_core #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic out_item_t stack_result(input logic [1:0] outcome,
			input logic signed [31:0] word, input logic last);
		out_item_t r;
		r.outcome    = outcome;
		r.word       = word;
		r.occupancy  = 4'(words_held);
		r.free_slots = 4'(DEPTH - words_held);
		r.last       = last;
		return r;
	endfunction

	task automatic predict_command(input in_item_t item);
		out_item_t          batch [$];
		logic signed [31:0] best;
		logic               want_odd;
		int                 match_total;
		int                 seen;
		op_t                op;
		op = op_t'(item.command);
		if (op == OP_NOP) begin
			commands_ignored++;
			return;
		end
		commands_sent++;
		if (op == OP_PUSH) begin
			if (words_held >= DEPTH) begin
				batch.push_back(stack_result(OC_FULL, 32'sd0, 1'b1));
			end else begin
				stack_words[words_held] = item.push_data;
				words_held++;
				batch.push_back(stack_result(OC_OK, item.push_data, 1'b1));
			end
		end else if (words_held == 0) begin
			batch.push_back(stack_result(OC_EMPTY, 32'sd0, 1'b1));
		end else begin
			case (op)
				OP_POP: begin
					words_held--;
					batch.push_back(stack_result(OC_OK, stack_words[words_held], 1'b1));
				end
				OP_PEEK: begin
					batch.push_back(stack_result(OC_OK, stack_words[words_held - 1], 1'b1));
				end
				OP_STATUS: begin
					if (words_held == DEPTH) begin
						batch.push_back(stack_result(OC_FULL, 32'sd0, 1'b1));
					end else begin
						for (int i = 0; i < words_held; i++)
							batch.push_back(stack_result(OC_OK, stack_words[i],
								i + 1 == words_held));
					end
				end
				OP_MAX: begin
					best = stack_words[0];
					for (int i = 1; i < words_held; i++)
						if (stack_words[i] > best)
							best = stack_words[i];
					batch.push_back(stack_result(OC_OK, best, 1'b1));
				end
				default: begin
					// low bit decides, so negative odd words count as odd
					want_odd = (op == OP_ODDS);
					match_total = 0;
					for (int i = 0; i < words_held; i++)
						if (stack_words[i][0] == want_odd)
							match_total++;
					if (match_total == 0) begin
						batch.push_back(stack_result(OC_NONE, 32'sd0, 1'b1));
					end else begin
						seen = 0;
						for (int i = 0; i < words_held; i++) begin
							if (stack_words[i][0] == want_odd) begin
								seen++;
								batch.push_back(stack_result(OC_OK, stack_words[i],
									seen == match_total));
							end
						end
					end
				end
			endcase
		end
		foreach (batch[k]) begin
			if (batch[k].outcome == OC_FULL)
				full_reports++;
			else if (batch[k].outcome == OC_EMPTY)
				empty_reports++;
			else if (batch[k].outcome == OC_NONE)
				none_reports++;
			pending_rsp.push_back(batch[k]);
		end
	endtask

	task automatic send_command(input op_t op, input logic signed [31:0] data);
		in_item_t item;
		item.command   = op;
		item.push_data = data;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (!req_ready);
		predict_command(item);
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_rsp.size() != 0);
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			results_checked++;
			if (pending_rsp.size() == 0) begin
				$error("unexpected item: outcome %0d word %0d", rsp.outcome, rsp.word);
				mismatch_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.outcome !== want.outcome) begin
					$error("outcome: expected %0d, got %0d", want.outcome, rsp.outcome);
					mismatch_count++;
				end
				if (rsp.word !== want.word) begin
					$error("word: expected %0d, got %0d", want.word, rsp.word);
					mismatch_count++;
				end
				if (rsp.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy, rsp.occupancy);
					mismatch_count++;
				end
				if (rsp.free_slots !== want.free_slots) begin
					$error("free_slots: expected %0d, got %0d", want.free_slots,
						rsp.free_slots);
					mismatch_count++;
				end
				if (rsp.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp.last);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_empty_stack();
		send_command(OP_POP, 32'sd0);
		send_command(OP_PEEK, -32'sd1);
		send_command(OP_STATUS, 32'sd0);
		send_command(OP_MAX, 32'sd0);
		send_command(OP_EVENS, 32'sd0);
		send_command(OP_ODDS, 32'sd0);
		send_command(OP_NOP, 32'sd12345);
	endtask

	task automatic test_no_match();
		send_command(OP_PUSH, 32'sd4);
		send_command(OP_ODDS, 32'sd0);
		send_command(OP_POP, 32'sd0);
		send_command(OP_PUSH, -32'sd7);
		send_command(OP_EVENS, 32'sd0);
	endtask

	task automatic test_full_stack();
		logic signed [31:0] extremes [7];
		extremes = '{32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd0, 32'sd1,
			32'sh80000001, 32'sh7ffffffe};
		foreach (extremes[i])
			send_command(OP_PUSH, extremes[i]);
		send_command(OP_PUSH, 32'sh55555555);
		send_command(OP_STATUS, 32'sd0);
		send_command(OP_MAX, 32'sd0);
		send_command(OP_ODDS, 32'sd0);
		send_command(OP_POP, 32'sd0);
		send_command(OP_STATUS, 32'sd0);
		wait_for_results();
	endtask

	task automatic test_random_traffic(input int n_items, input int idle_pct,
			input int stall_pct);
		int                 sent;
		int                 roll;
		bit                 filling;
		op_t                op;
		logic signed [31:0] data;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		filling = 1'b1;
		sent = 0;
		while (sent < n_items) begin
			// alternate runs of growth and shrinkage so full and empty both recur
			if (words_held == DEPTH)
				filling = 1'b0;
			else if (words_held == 0)
				filling = 1'b1;
			else if ($urandom_range(19) == 0)
				filling = !filling;
			roll = $urandom_range(99);
			if (roll < 3)
				op = OP_NOP;
			else if (roll < (filling ? 60 : 25))
				op = OP_PUSH;
			else if (roll < (filling ? 65 : 55))
				op = OP_POP;
			else
				op = op_t'($urandom_range(6, 2));
			case ($urandom_range(3))
				0: data = 32'($urandom_range(16)) - 32'd8;
				1: data = $urandom_range(1) ? 32'sh80000000 : 32'sh7fffffff;
				default: data = $urandom;
			endcase
			send_command(op, data);
			if (op != OP_NOP)
				sent++;
		end
		wait_for_results();
	endtask

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_stack();
		test_no_match();
		test_full_stack();
		test_random_traffic(95, 0, 0);
		test_random_traffic(90, 62, 0);
		test_random_traffic(90, 0, 62);
		test_random_traffic(95, 29, 29);
		recv_stall_pct = 0;
		repeat (40) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			$error("%0d expected items never arrived", pending_rsp.size());
			mismatch_count++;
		end
		$display("covered %0d commands and %0d unused codes, %0d result items checked",
			commands_sent, commands_ignored, results_checked);
		$display("stack reported full %0d, empty %0d and no match %0d times",
			full_reports, empty_reports, none_reports);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
